### rtl/core/edwt_pkg.sv
// edwt_pkg: shared constants and types for the edit distance with transposition unit
`timescale 1ns / 1ps

package edwt_pkg;

  // field widths fixed by the item format
  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 7;

  // largest reportable distance, larger values saturate
  localparam int DIST_MAX = 127;

  // default string capacity
  localparam int DEF_MAX_LEN = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SRC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TGT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CMP = 2'd2;

  // control from the sequencer to the row buffers
  typedef struct packed {
    logic restart;  // put the three banks back in their first roles
    logic rotate;   // end of row: two-back <- one-back <- now <- two-back
    logic we;       // write the current cell into the current row
  } row_ctl_t;

  // string store requests from the sequencer
  typedef struct packed {
    logic load_src;  // append one byte to the source string
    logic load_tgt;  // append one byte to the target string
    logic clear;     // empty both strings and drop the overflow flag
  } str_ctl_t;

endpackage

### rtl/core/edit_distance_with_transposition_unit.sv
// edit_distance_with_transposition_unit: top level with the matrix fill sequencer
`timescale 1ns / 1ps

// Edit distance with transposition. Load items (kind 0 source, kind 1 target)
// append one byte each and are taken while the unit is idle; a byte beyond MAX_LEN
// is dropped and sets too_long. A compute item (kind 2) returns one result
// with the distance (saturated at 127) and the flag, then both strings are
// empty again; kind 3 is ignored. One cell update unit fills the matrix one
// cell at a time, each cell a registered read of the row and string memories
// and then the update, plus a step per row to fetch its source byte. With
// either string empty the fill is skipped. Input stalls during a compute;
// loads are taken while a result still waits on the output.

module edit_distance_with_transposition_unit #(
  parameter int MAX_LEN = edwt_pkg::DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [edwt_pkg::KIND_W-1:0] in_kind,
  input  logic [edwt_pkg::SYM_W-1:0]  in_symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [edwt_pkg::DIST_W-1:0] out_distance,
  output logic                        out_too_long
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] diag_r, diag_nxt;
  logic [CW-1:0] res_r, res_nxt;
  logic          ovf_r, ovf_nxt;
  logic [edwt_pkg::SYM_W-1:0] s_cur_r, s_cur_nxt;
  logic [edwt_pkg::SYM_W-1:0] s_prev_r, s_prev_nxt;
  logic [edwt_pkg::SYM_W-1:0] t_prev_r, t_prev_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [edwt_pkg::DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic          out_too_long_r, out_too_long_nxt;

  logic          in_acc;
  logic          out_free;
  edwt_pkg::str_ctl_t str_ctl;
  edwt_pkg::row_ctl_t row_ctl;
  logic [edwt_pkg::SYM_W-1:0] src_q, tgt_q;
  logic [CW-1:0] src_count, tgt_count;
  logic          overflow;
  logic [CW-1:0] i_m1, j_m1, j_m3;
  logic [CW-1:0] ob_q, tb_q;
  logic [CW-1:0] above_v, left_v, diag_v, cell_v;
  logic          use_trans;
  logic [31:0]   res_wide;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign i_m1 = i_r - CW'(1);
  assign j_m1 = j_r - CW'(1);
  assign j_m3 = j_r - CW'(3);

  // string stores
  always_comb begin
    str_ctl.load_src = in_acc && (in_kind == edwt_pkg::KIND_SRC);
    str_ctl.load_tgt = in_acc && (in_kind == edwt_pkg::KIND_TGT);
    str_ctl.clear    = in_acc && (in_kind == edwt_pkg::KIND_CMP);
  end

  edwt_strings #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW),
    .AW      (AW)
  ) u_strings (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (str_ctl),
    .symbol    (in_symbol),
    .src_addr  (i_m1[AW-1:0]),
    .tgt_addr  (j_m1[AW-1:0]),
    .src_q     (src_q),
    .tgt_q     (tgt_q),
    .src_count (src_count),
    .tgt_count (tgt_count),
    .overflow  (overflow)
  );

  // row buffers
  edwt_rows #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW),
    .AW      (AW)
  ) u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (row_ctl),
    .ob_addr (j_m1[AW-1:0]),
    .tb_addr (j_m3[AW-1:0]),
    .wr_addr (j_m1[AW-1:0]),
    .wr_data (cell_v),
    .ob_q    (ob_q),
    .tb_q    (tb_q)
  );

  // cell operands, first row and first column come from the indexes
  always_comb begin
    above_v   = (i_r == CW'(1)) ? j_r : ob_q;
    left_v    = (j_r == CW'(1)) ? i_r : left_r;
    diag_v    = (j_r == CW'(1)) ? i_m1 : diag_r;
    use_trans = (i_r > CW'(2)) && (j_r > CW'(2));
  end

  edwt_cell #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW)
  ) u_cell (
    .above     (above_v),
    .left      (left_v),
    .diag      (diag_v),
    .two_back  (tb_q),
    .mismatch  (s_cur_r != tgt_q),
    .use_trans (use_trans),
    .cross_a   (s_prev_r != tgt_q),
    .cross_b   (s_cur_r != t_prev_r),
    .best      (cell_v)
  );

  // saturate the final distance
  assign res_wide = 32'(res_r);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    n_nxt            = n_r;
    m_nxt            = m_r;
    left_nxt         = left_r;
    diag_nxt         = diag_r;
    res_nxt          = res_r;
    ovf_nxt          = ovf_r;
    s_cur_nxt        = s_cur_r;
    s_prev_nxt       = s_prev_r;
    t_prev_nxt       = t_prev_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_distance_nxt = out_distance_r;
    out_too_long_nxt = out_too_long_r;
    row_ctl          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == edwt_pkg::KIND_CMP)) begin
          n_nxt   = src_count;
          m_nxt   = tgt_count;
          ovf_nxt = overflow;
          i_nxt   = CW'(1);
          j_nxt   = CW'(1);
          if ((src_count == '0) || (tgt_count == '0)) begin
            // empty string: distance is the other length
            res_nxt   = src_count | tgt_count;
            state_nxt = ST_DONE;
          end else begin
            row_ctl.restart = 1'b1;
            state_nxt       = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        // source byte for this row is being read
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if (j_r == CW'(1)) begin
          s_prev_nxt = s_cur_r;
          s_cur_nxt  = src_q;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        row_ctl.we = 1'b1;
        left_nxt   = cell_v;
        diag_nxt   = above_v;
        t_prev_nxt = tgt_q;
        if (j_r == m_r) begin
          if (i_r == n_r) begin
            res_nxt   = cell_v;
            state_nxt = ST_DONE;
          end else begin
            row_ctl.rotate = 1'b1;
            i_nxt          = i_r + CW'(1);
            j_nxt          = CW'(1);
            state_nxt      = ST_ROW;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = (res_wide > 32'(edwt_pkg::DIST_MAX))
                             ? edwt_pkg::DIST_W'(edwt_pkg::DIST_MAX)
                             : res_wide[edwt_pkg::DIST_W-1:0];
          out_too_long_nxt = ovf_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r            <= i_nxt;
    j_r            <= j_nxt;
    n_r            <= n_nxt;
    m_r            <= m_nxt;
    left_r         <= left_nxt;
    diag_r         <= diag_nxt;
    res_r          <= res_nxt;
    ovf_r          <= ovf_nxt;
    s_cur_r        <= s_cur_nxt;
    s_prev_r       <= s_prev_nxt;
    t_prev_r       <= t_prev_nxt;
    out_distance_r <= out_distance_nxt;
    out_too_long_r <= out_too_long_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_too_long = out_too_long_r;

endmodule

### rtl/core/edwt_strings.sv
// edwt_strings: source and target byte stores with fill counts and overflow flag
`timescale 1ns / 1ps

module edwt_strings #(
  parameter int MAX_LEN = edwt_pkg::DEF_MAX_LEN,
  parameter int CW      = $clog2(MAX_LEN + 1),
  parameter int AW      = $clog2(MAX_LEN)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  edwt_pkg::str_ctl_t       ctl,
  input  logic [edwt_pkg::SYM_W-1:0] symbol,
  input  logic [AW-1:0]            src_addr,
  input  logic [AW-1:0]            tgt_addr,
  output logic [edwt_pkg::SYM_W-1:0] src_q,
  output logic [edwt_pkg::SYM_W-1:0] tgt_q,
  output logic [CW-1:0]            src_count,
  output logic [CW-1:0]            tgt_count,
  output logic                     overflow
);

  logic [edwt_pkg::SYM_W-1:0] src_mem [MAX_LEN];
  logic [edwt_pkg::SYM_W-1:0] tgt_mem [MAX_LEN];

  logic [CW-1:0] src_count_r, src_count_nxt;
  logic [CW-1:0] tgt_count_r, tgt_count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_full, tgt_full;
  logic [AW-1:0] src_wr_addr, tgt_wr_addr;

  assign src_full    = (src_count_r == CW'(MAX_LEN));
  assign tgt_full    = (tgt_count_r == CW'(MAX_LEN));
  assign src_wr_addr = src_count_r[AW-1:0];
  assign tgt_wr_addr = tgt_count_r[AW-1:0];

  // fill counts and overflow flag
  always_comb begin
    src_count_nxt = src_count_r;
    tgt_count_nxt = tgt_count_r;
    ovf_nxt       = ovf_r;
    if (ctl.clear) begin
      src_count_nxt = '0;
      tgt_count_nxt = '0;
      ovf_nxt       = 1'b0;
    end else if (ctl.load_src) begin
      if (src_full) begin
        ovf_nxt = 1'b1;
      end else begin
        src_count_nxt = src_count_r + CW'(1);
      end
    end else if (ctl.load_tgt) begin
      if (tgt_full) begin
        ovf_nxt = 1'b1;
      end else begin
        tgt_count_nxt = tgt_count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r <= '0;
      tgt_count_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      src_count_r <= src_count_nxt;
      tgt_count_r <= tgt_count_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // source store, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.load_src && !src_full) begin
      src_mem[src_wr_addr] <= symbol;
    end
    src_q <= src_mem[src_addr];
  end

  // target store, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.load_tgt && !tgt_full) begin
      tgt_mem[tgt_wr_addr] <= symbol;
    end
    tgt_q <= tgt_mem[tgt_addr];
  end

  assign src_count = src_count_r;
  assign tgt_count = tgt_count_r;
  assign overflow  = ovf_r;

endmodule

### rtl/core/edwt_rows.sv
// edwt_rows: three rotating distance-row memories (two-back, one-back, now)
`timescale 1ns / 1ps

module edwt_rows #(
  parameter int MAX_LEN = edwt_pkg::DEF_MAX_LEN,
  parameter int CW      = $clog2(MAX_LEN + 1),
  parameter int AW      = $clog2(MAX_LEN)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  edwt_pkg::row_ctl_t ctl,
  input  logic [AW-1:0]      ob_addr,
  input  logic [AW-1:0]      tb_addr,
  input  logic [AW-1:0]      wr_addr,
  input  logic [CW-1:0]      wr_data,
  output logic [CW-1:0]      ob_q,
  output logic [CW-1:0]      tb_q
);

  localparam int NB = 3;

  logic [1:0]    ob_sel_r, ob_sel_nxt;
  logic [1:0]    tb_sel_r, tb_sel_nxt;
  logic [1:0]    nw_sel_r, nw_sel_nxt;
  logic [CW-1:0] bank_q [NB];

  // bank roles
  always_comb begin
    ob_sel_nxt = ob_sel_r;
    tb_sel_nxt = tb_sel_r;
    nw_sel_nxt = nw_sel_r;
    if (ctl.restart) begin
      ob_sel_nxt = 2'd0;
      tb_sel_nxt = 2'd1;
      nw_sel_nxt = 2'd2;
    end else if (ctl.rotate) begin
      tb_sel_nxt = ob_sel_r;
      ob_sel_nxt = nw_sel_r;
      nw_sel_nxt = tb_sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_sel_r <= 2'd0;
      tb_sel_r <= 2'd1;
      nw_sel_r <= 2'd2;
    end else begin
      ob_sel_r <= ob_sel_nxt;
      tb_sel_r <= tb_sel_nxt;
      nw_sel_r <= nw_sel_nxt;
    end
  end

  // one memory per bank, columns 1..MAX_LEN at addresses 0..MAX_LEN-1
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [CW-1:0] mem [MAX_LEN];
    logic [AW-1:0] rd_addr;

    assign rd_addr = (tb_sel_r == 2'(b)) ? tb_addr : ob_addr;

    always_ff @(posedge clk) begin
      if (ctl.we && (nw_sel_r == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      bank_q[b] <= mem[rd_addr];
    end
  end

  // route registered bank outputs by role
  always_comb begin
    case (ob_sel_r)
      2'd0:    ob_q = bank_q[0];
      2'd1:    ob_q = bank_q[1];
      2'd2:    ob_q = bank_q[2];
      default: ob_q = bank_q[0];
    endcase
    case (tb_sel_r)
      2'd0:    tb_q = bank_q[0];
      2'd1:    tb_q = bank_q[1];
      2'd2:    tb_q = bank_q[2];
      default: tb_q = bank_q[0];
    endcase
  end

endmodule

### rtl/core/edwt_cell.sv
// edwt_cell: shared cell update unit, minimum over edit and transposition candidates
`timescale 1ns / 1ps

module edwt_cell #(
  parameter int MAX_LEN = edwt_pkg::DEF_MAX_LEN,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  logic [CW-1:0] above,
  input  logic [CW-1:0] left,
  input  logic [CW-1:0] diag,
  input  logic [CW-1:0] two_back,
  input  logic          mismatch,   // current source and target characters differ
  input  logic          use_trans,  // row and column both past the second
  input  logic          cross_a,    // previous source char differs from current target char
  input  logic          cross_b,    // current source char differs from previous target char
  output logic [CW-1:0] best
);

  localparam int VW = CW + 2;

  logic [VW-1:0] del_c, ins_c, sub_c, trn_c;
  logic [VW-1:0] min_a, min_b, min_c;

  // candidates
  assign del_c = VW'(above) + VW'(1);
  assign ins_c = VW'(left) + VW'(1);
  assign sub_c = VW'(diag) + VW'(mismatch);
  assign trn_c = VW'(two_back) + VW'(1) + VW'(cross_a) + VW'(cross_b);

  // minimum
  assign min_a = (ins_c < sub_c) ? ins_c : sub_c;
  assign min_b = (del_c < min_a) ? del_c : min_a;
  assign min_c = (use_trans && (trn_c < min_b)) ? trn_c : min_b;

  assign best = min_c[CW-1:0];

endmodule

### bench/tb_edit_distance_with_transposition_unit.sv
// tb_edit_distance_with_transposition_unit: self-checking bench for the edit distance unit
`timescale 1ns / 1ps

module tb_edit_distance_with_transposition_unit;
  import edwt_pkg::*;

  localparam int STR_CAP     = DEF_MAX_LEN;
  localparam int ITEM_BUDGET = 1950;
  localparam int TAIL_CYCLES = 50;
  // kind left unused by the block
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef logic [SYM_W-1:0] sym_q_t[$];

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    bit                typed;
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } stim_row_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } dist_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic              out_too_long;

  // predictor state
  logic [SYM_W-1:0] src_bytes[$];
  logic [SYM_W-1:0] tgt_bytes[$];
  logic             overflow_pending = 1'b0;
  dist_result_t     pending_results[$];

  int err_count = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  // directed items: expected values typed in where they are obvious
  stim_row_t directed_rows [23] = '{
    '{KIND_CMP,  8'h00, 1'b1, 7'd0, 1'b0},  // both strings empty after reset
    '{KIND_NONE, 8'hff, 1'b0, 7'd0, 1'b0},  // unused kind, ignored
    '{KIND_CMP,  8'hff, 1'b1, 7'd0, 1'b0},
    '{KIND_SRC,  8'h00, 1'b0, 7'd0, 1'b0},
    '{KIND_SRC,  8'hff, 1'b0, 7'd0, 1'b0},
    '{KIND_SRC,  8'h55, 1'b0, 7'd0, 1'b0},
    '{KIND_CMP,  8'h00, 1'b1, 7'd3, 1'b0},  // empty target
    '{KIND_TGT,  8'haa, 1'b0, 7'd0, 1'b0},
    '{KIND_TGT,  8'h00, 1'b0, 7'd0, 1'b0},
    '{KIND_CMP,  8'h00, 1'b1, 7'd2, 1'b0},  // empty source
    '{KIND_SRC,  8'h61, 1'b0, 7'd0, 1'b0},
    '{KIND_TGT,  8'h61, 1'b0, 7'd0, 1'b0},
    '{KIND_SRC,  8'h62, 1'b0, 7'd0, 1'b0},
    '{KIND_TGT,  8'h62, 1'b0, 7'd0, 1'b0},
    '{KIND_SRC,  8'h63, 1'b0, 7'd0, 1'b0},
    '{KIND_TGT,  8'h64, 1'b0, 7'd0, 1'b0},
    '{KIND_SRC,  8'h64, 1'b0, 7'd0, 1'b0},
    '{KIND_TGT,  8'h63, 1'b0, 7'd0, 1'b0},
    '{KIND_CMP,  8'h00, 1'b0, 7'd0, 1'b0},  // swapped tail, transposition path
    '{KIND_SRC,  8'h78, 1'b0, 7'd0, 1'b0},
    '{KIND_NONE, 8'h79, 1'b0, 7'd0, 1'b0},  // unused kind between loads
    '{KIND_TGT,  8'h78, 1'b0, 7'd0, 1'b0},
    '{KIND_CMP,  8'h00, 1'b1, 7'd0, 1'b0}
  };

  edit_distance_with_transposition_unit #(
    .MAX_LEN(STR_CAP)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_symbol   (in_symbol),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_distance(out_distance),
    .out_too_long(out_too_long)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // distance with the restricted transposition step, three rolling rows
  function automatic logic [DIST_W-1:0] damerau_distance(input sym_q_t src, input sym_q_t tgt);
    int n;
    int m;
    int best;
    int trans;
    int prev2 [0:STR_CAP];
    int prev1 [0:STR_CAP];
    int cur   [0:STR_CAP];
    n = src.size();
    m = tgt.size();
    if (n == 0) return DIST_W'(m);
    if (m == 0) return DIST_W'(n);
    for (int j = 0; j <= STR_CAP; j++) begin
      prev1[j] = j;
      prev2[j] = 0;
      cur[j]   = 0;
    end
    for (int i = 1; i <= n; i++) begin
      cur[0] = i;
      for (int j = 1; j <= m; j++) begin
        best = prev1[j] + 1;
        if (cur[j-1] + 1 < best) best = cur[j-1] + 1;
        if (prev1[j-1] + (src[i-1] != tgt[j-1]) < best)
          best = prev1[j-1] + (src[i-1] != tgt[j-1]);
        if (i > 2 && j > 2) begin
          trans = prev2[j-2] + 1 + (src[i-2] != tgt[j-1]) + (src[i-1] != tgt[j-2]);
          if (trans < best) best = trans;
        end
        cur[j] = best;
      end
      prev2 = prev1;
      prev1 = cur;
    end
    if (prev1[m] > DIST_MAX) return DIST_W'(DIST_MAX);
    return DIST_W'(prev1[m]);
  endfunction

  // offer one item, wait for it to be taken, then update the predictor
  task automatic put_item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s,
                          input bit typed = 1'b0, input logic [DIST_W-1:0] t_dist = '0,
                          input logic t_long = 1'b0);
    int gap;
    dist_result_t res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid  <= 1'b0;
      in_kind   <= KIND_W'($urandom);
      in_symbol <= SYM_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= k;
    in_symbol <= s;
    do @(posedge clk); while (in_stall);
    case (k)
      KIND_SRC: begin
        if (src_bytes.size() < STR_CAP) src_bytes = {src_bytes, s};
        else overflow_pending = 1'b1;
      end
      KIND_TGT: begin
        if (tgt_bytes.size() < STR_CAP) tgt_bytes = {tgt_bytes, s};
        else overflow_pending = 1'b1;
      end
      KIND_CMP: begin
        res.distance = typed ? t_dist : damerau_distance(src_bytes, tgt_bytes);
        res.too_long = typed ? t_long : overflow_pending;
        pending_results = {pending_results, res};
        src_bytes.delete();
        tgt_bytes.delete();
        overflow_pending = 1'b0;
      end
      default: ;
    endcase
    if (k != KIND_NONE) items_sent++;
  endtask

  // small alphabet for matches and swaps, full byte range now and then
  function automatic logic [SYM_W-1:0] pick_symbol(input int alpha);
    if (alpha == 0) return SYM_W'($urandom);
    return SYM_W'(8'h61 + $urandom_range(alpha - 1));
  endfunction

  // one load sequence followed by a compute, or a burst of noise
  task automatic send_sequence();
    logic [SYM_W-1:0] s_list[$];
    logic [SYM_W-1:0] t_list[$];
    logic [SYM_W-1:0] tmp;
    int shape;
    int n;
    int m;
    int alpha;
    int pos;
    shape = $urandom_range(99);
    alpha = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
    if (shape < 15) begin
      // noise: any kind, any symbol
      repeat ($urandom_range(1, 6)) put_item(KIND_W'($urandom), SYM_W'($urandom));
      return;
    end
    if (shape < 17) begin
      // one string overflows
      n = STR_CAP + $urandom_range(1, 3);
      m = $urandom_range(4);
      if ($urandom_range(1)) begin
        pos = n;
        n = m;
        m = pos;
      end
    end else if (shape < 22) begin
      n = $urandom_range(STR_CAP);
      m = $urandom_range(STR_CAP);
    end else begin
      n = $urandom_range(8);
      m = $urandom_range(8);
    end
    repeat (n) s_list = {s_list, pick_symbol(alpha)};
    if (shape >= 22 && $urandom_range(1)) begin
      // target as an edited copy of the source
      t_list = s_list;
      repeat ($urandom_range(3)) begin
        pos = $urandom_range(8);
        case ($urandom_range(3))
          0: if (pos + 1 < t_list.size()) begin
            tmp = t_list[pos];
            t_list[pos] = t_list[pos+1];
            t_list[pos+1] = tmp;
          end
          1: if (pos < t_list.size()) t_list[pos] = pick_symbol(alpha);
          2: if (pos < t_list.size()) t_list.delete(pos);
          default: if (pos <= t_list.size()) t_list.insert(pos, pick_symbol(alpha));
        endcase
      end
    end else begin
      repeat (m) t_list = {t_list, pick_symbol(alpha)};
    end
    // interleave source and target loads
    while (s_list.size() != 0 || t_list.size() != 0) begin
      if (t_list.size() == 0 || (s_list.size() != 0 && $urandom_range(1)))
        put_item(KIND_SRC, s_list.pop_front());
      else
        put_item(KIND_TGT, t_list.pop_front());
    end
    put_item(KIND_CMP, SYM_W'($urandom));
  endtask

  // result side: random stall, compare each taken item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: distance %0d too_long %0b", out_distance, out_too_long);
        err_count++;
      end else begin
        if (out_distance !== pending_results[0].distance) begin
          $error("distance: expected %0d, got %0d", pending_results[0].distance,
                 out_distance);
          err_count++;
        end
        if (out_too_long !== pending_results[0].too_long) begin
          $error("too_long: expected %0b, got %0b", pending_results[0].too_long,
                 out_too_long);
          err_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      put_item(directed_rows[r].kind, directed_rows[r].symbol, directed_rows[r].typed,
               directed_rows[r].distance, directed_rows[r].too_long);

    // full source store plus one dropped byte, empty target
    repeat (STR_CAP + 1) put_item(KIND_SRC, SYM_W'($urandom));
    put_item(KIND_CMP, 8'h00, 1'b1, DIST_W'(STR_CAP), 1'b1);

    // random part in idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 65; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 65; end
        default: begin sender_idle_pct = 27; stall_pct = 27; end
      endcase
      while (items_sent < ITEM_BUDGET * (ph + 1) / 4) send_sequence();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
